@@ rtl/core/bb3_pkg.sv @@
// Shared types and constants for the 3x3 edge-normalised box blur.
// No dependencies; imported by all but bb3_ram and bb3_checker.
package bb3_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 1024;
    localparam int unsigned DEF_MAX_HEIGHT = 1024;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned PIX_W          = 24;
    localparam int unsigned POS_W          = 10;
    localparam int unsigned CFG_DIM_W      = 11;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;

    typedef logic [PIX_W-1:0] pix_t;   // {red, green, blue}

    // one classified pixel handed from front to back
    typedef struct packed {
        pix_t [2:0][2:0]   win;      // [row][col], row 2 / col 2 newest
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              up_ok;    // row >= 1
        logic              row_ge2;
        logic              low;      // last row of frame
        logic              left_ok;  // col >= 1
        logic              col_ge2;
        logic              right;    // last column of frame
    } job_t;

    // reciprocal of 2n, rounded up, for 16 fraction bits
    function automatic logic [15:0] recip(input logic [3:0] n);
        logic [15:0] m;
        case (n)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5462;
            4'd9:    m = 16'd3641;
            default: m = 16'd32768;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/bb3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/bb3_front.sv @@
// Front end: accepts pixels, keeps the position counters, line stores and
// 3x3 window, and classifies each pixel into a job. Uses bb3_pkg, bb3_ram.
module bb3_front #(
    parameter int unsigned MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]          width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]         height,
    input  logic                                    restart,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  bb3_pkg::pix_t                           s_pix,
    input  logic                                    q_full,
    output logic                                    q_push,
    output bb3_pkg::job_t                           q_job
);
    import bb3_pkg::*;

    localparam int unsigned CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    localparam logic F_IDLE = 1'b0;
    localparam logic F_WR   = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] col_reg, col_next, cur_col_reg, eff_col;
    logic [RW-1:0] row_reg, row_next, cur_row_reg, eff_row;
    pix_t          pix_reg;
    pix_t [2:0][2:0] win_reg;
    pix_t          top, mid;
    logic          accept, wrap;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == F_IDLE) && !q_full;

    // counters past the frame (after a shrink) restart at the origin
    assign wrap    = (32'(col_reg) >= 32'(width)) || (32'(row_reg) >= 32'(height));
    assign eff_col = wrap ? '0 : col_reg;
    assign eff_row = wrap ? '0 : row_reg;

    // line stores: older row and newer row
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_old (
        .aclk(aclk), .we(state_reg == F_WR), .waddr(cur_col_reg), .wdata(mid),
        .raddr(eff_col), .rdata(top)
    );
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_new (
        .aclk(aclk), .we(state_reg == F_WR), .waddr(cur_col_reg), .wdata(pix_reg),
        .raddr(eff_col), .rdata(mid)
    );

    // next position
    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_WR;
                end
            end
            F_WR: begin
                state_next = F_IDLE;
                if (32'(cur_col_reg) + 32'd1 >= 32'(width)) begin
                    col_next = '0;
                    row_next = (32'(cur_row_reg) + 32'd1 >= 32'(height)) ? '0
                               : cur_row_reg + 1'b1;
                end else begin
                    col_next = cur_col_reg + 1'b1;
                    row_next = cur_row_reg;
                end
            end
            default: state_next = F_IDLE;
        endcase
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // payload: latched word and window shift
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg     <= s_pix;
            cur_col_reg <= eff_col;
            cur_row_reg <= eff_row;
        end
        if (state_reg == F_WR) begin
            for (int a = 0; a < 3; a++) begin
                win_reg[a][0] <= win_reg[a][1];
                win_reg[a][1] <= win_reg[a][2];
            end
            win_reg[0][2] <= top;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= pix_reg;
        end
    end

    // job built from the shifted window
    always_comb begin
        q_push = (state_reg == F_WR);
        for (int a = 0; a < 3; a++) begin
            q_job.win[a][0] = win_reg[a][1];
            q_job.win[a][1] = win_reg[a][2];
        end
        q_job.win[0][2] = top;
        q_job.win[1][2] = mid;
        q_job.win[2][2] = pix_reg;
        q_job.row     = POS_W'(cur_row_reg);
        q_job.col     = POS_W'(cur_col_reg);
        q_job.up_ok   = cur_row_reg != '0;
        q_job.row_ge2 = 32'(cur_row_reg) >= 32'd2;
        q_job.low     = 32'(cur_row_reg) + 32'd1 == 32'(height);
        q_job.left_ok = cur_col_reg != '0;
        q_job.col_ge2 = 32'(cur_col_reg) >= 32'd2;
        q_job.right   = 32'(cur_col_reg) + 32'd1 == 32'(width);
    end
endmodule

@@ rtl/core/bb3_queue.sv @@
// Short job queue between front and back ends.
// Uses bb3_pkg.
module bb3_queue #(
    parameter int unsigned DEPTH = bb3_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bb3_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output bb3_pkg::job_t head
);
    import bb3_pkg::*;

    localparam int unsigned AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

    job_t            slot_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg;

    assign full  = 32'(count_reg) == DEPTH;
    assign avail = count_reg != '0;
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_job;
        end
    end
endmodule

@@ rtl/core/bb3_back.sv @@
// Back end: walks the up to four centres of a job, sums the in-frame
// neighbours, divides by the count with rounding. Uses bb3_pkg.
module bb3_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          avail,
    input  bb3_pkg::job_t job,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,
    output logic          m_tlast
);
    import bb3_pkg::*;

    localparam logic [1:0] B_PICK = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_FIX  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [2:0][11:0]  sum_reg;
    logic [2:0][12:0]  q0_reg;
    logic [3:0]        n_reg;
    logic [POS_W-1:0]  y_reg, x_reg;
    logic              last_reg;
    logic              ov_reg;
    logic [2:0][7:0]   oc_reg;
    logic [POS_W-1:0]  oy_reg, ox_reg;
    logic              ol_reg;

    logic              a_sel, b_sel, hit, later, out_free;
    logic [2:0]        rs, cs;
    logic [1:0]        nr, nc;
    logic [3:0]        n;
    logic [2:0][11:0]  sum;
    logic [2:0][7:0]   mean;

    function automatic logic combo_ok(input job_t j, input logic [1:0] k);
        return (k[1] ? j.low : j.up_ok) && (k[0] ? j.right : j.left_ok);
    endfunction

    assign a_sel    = idx_reg[1];
    assign b_sel    = idx_reg[0];
    assign hit      = combo_ok(job, idx_reg);
    assign out_free = !ov_reg || m_tready;

    // any valid combination after this one
    always_comb begin
        later = 1'b0;
        for (int k = 1; k < 4; k++) begin
            if (k > int'(idx_reg) && combo_ok(job, 2'(k))) begin
                later = 1'b1;
            end
        end
    end

    // row and column selects of the window for this centre
    always_comb begin
        rs = a_sel ? {1'b1, job.up_ok, 1'b0} : {1'b1, 1'b1, job.row_ge2};
        cs = b_sel ? {1'b1, job.left_ok, 1'b0} : {1'b1, 1'b1, job.col_ge2};
        nr = 2'(rs[0]) + 2'(rs[1]) + 2'(rs[2]);
        nc = 2'(cs[0]) + 2'(cs[1]) + 2'(cs[2]);
        n  = 4'(nr) * 4'(nc);
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (rs[i] && cs[j]) begin
                        sum[ch] = sum[ch] + 12'(job.win[i][j][8*(2-ch) +: 8]);
                    end
                end
            end
        end
    end

    // correction step of the reciprocal division, then clamp
    always_comb begin
        logic [13:0] t;
        logic [17:0] back;
        logic [12:0] q;
        for (int ch = 0; ch < 3; ch++) begin
            t    = {1'b0, sum_reg[ch], 1'b0} + 14'(n_reg);
            back = 18'(q0_reg[ch]) * 18'({n_reg, 1'b0});
            q    = (back > 18'(t)) ? q0_reg[ch] - 1'b1 : q0_reg[ch];
            mean[ch] = (q > 13'd255) ? 8'd255 : q[7:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        case (state_reg)
            B_PICK: begin
                if (avail) begin
                    if (hit) begin
                        state_next = B_MUL;
                    end else if (idx_reg == 2'd3) begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            B_MUL: state_next = B_FIX;
            B_FIX: begin
                if (out_free) begin
                    state_next = B_PICK;
                    if (last_reg) begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = B_PICK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_PICK;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == B_FIX && out_free) begin
                ov_reg <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == B_PICK) begin
            sum_reg  <= sum;
            n_reg    <= n;
            y_reg    <= a_sel ? job.row : job.row - 1'b1;
            x_reg    <= b_sel ? job.col : job.col - 1'b1;
            last_reg <= !later;
        end
        if (state_reg == B_MUL) begin
            for (int ch = 0; ch < 3; ch++) begin
                q0_reg[ch] <= 13'((30'({sum_reg[ch], 1'b0} + 13'(n_reg))
                                  * 30'(recip(n_reg))) >> 16);
            end
        end
        if (state_reg == B_FIX && out_free) begin
            oc_reg <= mean;
            oy_reg <= y_reg;
            ox_reg <= x_reg;
            ol_reg <= last_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, ox_reg, oy_reg, oc_reg[2], oc_reg[1], oc_reg[0]};
    assign m_tlast  = ol_reg;
endmodule

@@ rtl/core/box_blur_3x3_edge_normalized.sv @@
// 3x3 box blur with edge normalisation for an RGB raster stream. The front
// end reads the line stores for a pixel word, then writes them and shifts
// the window, taking no new word meanwhile; the back end sums, multiplies
// by the reciprocal and corrects each result, skips empty centre slots in
// its pick state, and a pixel yields 0 to 4 results, four only at the last
// row and column. A two-entry job queue decouples the two, and the result
// register lets the next pixel be accepted while a result waits. Line stores
// need no clearing after reset. Writing either frame register restarts the
// frame at row 0, column 0. Uses bb3_pkg, bb3_front, bb3_queue, bb3_back.
module box_blur_3x3_edge_normalized #(
    parameter int unsigned MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_col, pad
    output logic        m_tlast    // last_of_run
);
    import bb3_pkg::*;

    localparam int unsigned WDW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HDW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DIM_W-1:0] fw_reg, fh_reg;
    logic [WDW-1:0]       width;
    logic [HDW-1:0]       height;
    logic                 wr, restart, q_full, q_push, q_avail, q_pop;
    job_t                 q_job, q_head;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign restart = wr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= RST_FRAME_WIDTH;
            fh_reg <= RST_FRAME_HEIGHT;
        end else if (wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  fw_reg <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= pwdata[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(fw_reg);
            REG_FRAME_HEIGHT: prdata = 32'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    // zero acts as one, oversize as the maximum
    always_comb begin
        if (fw_reg == '0)                      width = WDW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)      width = WDW'(MAX_WIDTH);
        else                                   width = WDW'(fw_reg);
        if (fh_reg == '0)                      height = HDW'(1);
        else if (32'(fh_reg) > MAX_HEIGHT)     height = HDW'(MAX_HEIGHT);
        else                                   height = HDW'(fh_reg);
    end

    // internal pixel is {red, green, blue}, red in the top byte
    bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .width(width), .height(height),
        .restart(restart), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_pix({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .q_full(q_full), .q_push(q_push), .q_job(q_job)
    );

    bb3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_job(q_job),
        .full(q_full), .pop(q_pop), .avail(q_avail), .head(q_head)
    );

    bb3_back u_back (
        .aclk(aclk), .aresetn(aresetn), .avail(q_avail), .job(q_head),
        .pop(q_pop), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

@@ rtl/core/bb3_checker.sv @@
// Port-level checks for the box blur, bound to the top level.
// No package dependency.
module bb3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // nothing in flight straight after reset
    a_rst: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // the front end never takes words back to back
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // padding bits stay clear and the register port stays ready
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:44] == 4'b0 && pready)
        else $error("padding set or port not ready");
endmodule

bind box_blur_3x3_edge_normalized bb3_checker u_bb3_checker (
    .aclk(aclk), .aresetn(aresetn), .pready(pready), .s_tvalid(s_tvalid),
    .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

@@ tb/box_blur_3x3_edge_normalized_chk.sv @@
`timescale 1ns / 1ps
// Checker for the 3x3 box blur: watches the pixel, result and register ports,
// predicts every blurred result and compares it. Depends on bb3_pkg only.
module box_blur_3x3_edge_normalized_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    import bb3_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } blur_t;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;

    logic [10:0] width_reg, height_reg;
    pix_t        prev_rows [2][MAXW];   // [0] one row up, [1] two rows up
    pix_t        win [3][3];            // [row][col], index 2 newest
    int          cur_row, cur_col;
    blur_t       blur_q[$];

    function automatic int eff_dim(input logic [10:0] v, input int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : int'(v);
    endfunction

    // mean of the in-image neighbours of (y,x), window anchored at (r,c)
    function automatic blur_t mean_at(input int y, input int x, input int r,
                                      input int c, input int h, input int w);
        blur_t res;
        int sr, sg, sb, n, wr, wc;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int i = y - 1; i <= y + 1; i++) begin
            for (int j = x - 1; j <= x + 1; j++) begin
                wr = i - (r - 2);
                wc = j - (c - 2);
                if (i < 0 || i >= h || j < 0 || j >= w) continue;
                if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
                sr += win[wr][wc][23:16];
                sg += win[wr][wc][15:8];
                sb += win[wr][wc][7:0];
                n++;
            end
        end
        if (n == 0) n = 1;
        res.red   = 8'((2 * sr + n) / (2 * n));
        res.green = 8'((2 * sg + n) / (2 * n));
        res.blue  = 8'((2 * sb + n) / (2 * n));
        res.row   = 10'(y);
        res.col   = 10'(x);
        res.last  = 1'b0;
        return res;
    endfunction

    task automatic blur_pixel(input pix_t pix);
        int w, h, r, c, ny, nx, k;
        int ys[2], xs[2];
        pix_t top, mid;
        blur_t res;
        w = eff_dim(width_reg, MAXW);
        h = eff_dim(height_reg, MAXH);
        r = cur_row; c = cur_col;
        ny = 0; nx = 0; k = 0;
        if (c >= w || r >= h) begin
            r = 0; c = 0;
        end
        top = prev_rows[1][c];
        mid = prev_rows[0][c];
        prev_rows[1][c] = mid;
        prev_rows[0][c] = pix;
        for (int a = 0; a < 3; a++) begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        if (r >= 1) ys[ny++] = r - 1;
        if (r == h - 1) ys[ny++] = r;
        if (c >= 1) xs[nx++] = c - 1;
        if (c == w - 1) xs[nx++] = c;
        // upper row first, then left column first
        for (int a = 0; a < ny; a++) begin
            for (int b = 0; b < nx; b++) begin
                res = mean_at(ys[a], xs[b], r, c, h, w);
                k++;
                res.last = (k == ny * nx);
                blur_q.push_back(res);
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endtask

    task automatic check_word();
        blur_t got, want;
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.row   = m_tdata[33:24];
        got.col   = m_tdata[43:34];
        got.last  = m_tlast;
        result_count++;
        if (blur_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h", $time, got);
            fail_count++;
            return;
        end
        want = blur_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
            $display("%0t: result mismatch, expected r%0d g%0d b%0d (%0d,%0d) last%0d",
                     $time, want.red, want.green, want.blue, want.row, want.col,
                     want.last);
            $display("%0t:                  actual   r%0d g%0d b%0d (%0d,%0d) last%0d",
                     $time, got.red, got.green, got.blue, got.row, got.col,
                     got.last);
            fail_count++;
        end
    endtask

    assign pending = blur_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            cur_row = 0;
            cur_col = 0;
        end else begin
            // register write restarts the frame
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_FRAME_WIDTH, 2'b00}) begin
                    width_reg <= pwdata[10:0];
                    cur_row = 0; cur_col = 0;
                end else if (paddr == {REG_FRAME_HEIGHT, 2'b00}) begin
                    height_reg <= pwdata[10:0];
                    cur_row = 0; cur_col = 0;
                end
            end
            if (s_tvalid && s_tready)
                blur_pixel({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
            if (m_tvalid && m_tready)
                check_word();
        end
    end
endmodule

@@ tb/box_blur_3x3_edge_normalized_tb.sv @@
`timescale 1ns / 1ps
// Top of the box blur testbench: clock, reset, pixel and register stimulus,
// random result back-pressure and the verdict. Uses bb3_pkg and the checker.
module box_blur_3x3_edge_normalized_tb;
    import bb3_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_tvalid, s_tready;
    logic [23:0] s_tdata;     // in_red, in_green, in_blue
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;     // out_red, out_green, out_blue, out_row, out_col, pad
    logic        m_tlast;     // last_of_run
    int          fail_count, pending, result_count;
    int          pixels_sent, frames_set, quiet_cycles, stall_left, ready_draw;
    bit          no_idle;

    box_blur_3x3_edge_normalized dut (.*);

    box_blur_3x3_edge_normalized_chk chk (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .m_tlast, .fail_count, .pending, .result_count
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // result side back-pressure, a fresh random wait per word, none when no_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            ready_draw = no_idle ? 0 : $urandom_range(0, 15);
            m_tready   <= (ready_draw == 0);
            stall_left <= (ready_draw > 0) ? ready_draw - 1 : 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: no word moving on any port for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // quiesce before touching the frame registers
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
        settle();
        reg_write(REG_FRAME_WIDTH, w);
        reg_write(REG_FRAME_HEIGHT, h);
        frames_set++;
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan());
    endtask

    initial begin
        int w, h, n;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        pixels_sent = 0; frames_set = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full 3x3 frame of saturated pixels, then of alternating bit patterns
        set_frame(3, 3);
        repeat (9) send_pixel(8'd255, 8'd255, 8'd255);
        for (int i = 0; i < 9; i++)
            if (i[0]) send_pixel(8'hAA, 8'h55, 8'h00);
            else      send_pixel(8'h55, 8'hAA, 8'hFF);
        // zero dimensions act as one: every pixel is its own result
        set_frame(0, 0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd1, 8'd128);
        // oversize width clamps to the maximum; single row frame
        set_frame(2047, 1);
        send_random(4);
        // single column, oversize height
        set_frame(1, 2047);
        send_random(6);

        // random small frames, some whole, some cut short by a restart
        while (pixels_sent < 330) begin
            no_idle = ($urandom_range(0, 3) == 0);
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 10);
            n = $urandom_range(1, 2 * w * h);
            if (n > 60) n = 60;
            set_frame(w, h);
            send_random(n);
        end

        // one wider single row at full rate, running through the wrap
        no_idle = 1'b1;
        set_frame(24, 1);
        send_random(27);
        no_idle = 1'b0;

        settle();
        $display("Covered %0d pixels over %0d frame settings, %0d blurred results checked.",
                 pixels_sent, frames_set, result_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ box_blur_3x3_edge_normalized.f @@
rtl/core/bb3_pkg.sv
rtl/core/bb3_ram.sv
rtl/core/bb3_front.sv
rtl/core/bb3_queue.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_edge_normalized.sv
rtl/core/bb3_checker.sv
tb/box_blur_3x3_edge_normalized_chk.sv
tb/box_blur_3x3_edge_normalized_tb.sv
